FILE: rtl/sha1eng_pkg.sv
// Shared types and constants for the SHA-1 hash engine.
package sha1eng_pkg;

    localparam int NUM_CHAIN = 5;
    localparam int NUM_SCHED = 16;
    localparam int ROUND_W   = 7;

    localparam logic [31:0] INIT_H [NUM_CHAIN] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_00_19 = 32'h5A827999;
    localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
    localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
    localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

    localparam logic [ROUND_W-1:0] ROUND_20   = 7'd20;
    localparam logic [ROUND_W-1:0] ROUND_40   = 7'd40;
    localparam logic [ROUND_W-1:0] ROUND_60   = 7'd60;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [2:0] LAST_WORD_IDX = 3'd4;

    // Working variables a..e
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } sha1eng_vars_t;

    // Round unit control
    typedef struct packed {
        logic               load;
        logic               step;
        logic [ROUND_W-1:0] round;
    } sha1eng_rnd_ctl_t;

    // Block buffer / schedule control
    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       step;
    } sha1eng_buf_ctl_t;

endpackage

FILE: rtl/sha1eng_msgbuf.sv
// Block buffer: byte-wise fill, then 16-word sliding message schedule.
module sha1eng_msgbuf (
    input  logic                      aclk,
    input  sha1eng_pkg::sha1eng_buf_ctl_t ctl,
    output logic [31:0]               sched_word
);
    import sha1eng_pkg::*;

    logic [31:0] word_reg [NUM_SCHED];
    logic [31:0] mix;
    logic [31:0] new_word;

    // W[t+16] = rotl1(W[t+13] ^ W[t+8] ^ W[t+2] ^ W[t]), window starts at W[t]
    assign mix        = word_reg[13] ^ word_reg[8] ^ word_reg[2] ^ word_reg[0];
    assign new_word   = {mix[30:0], mix[31]};
    assign sched_word = word_reg[0];

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            for (int i = 0; i < NUM_SCHED - 1; i++) begin
                word_reg[i] <= {word_reg[i][23:0], word_reg[i+1][31:24]};
            end
            word_reg[NUM_SCHED-1] <= {word_reg[NUM_SCHED-1][23:0], ctl.push_byte};
        end else if (ctl.step) begin
            for (int i = 0; i < NUM_SCHED - 1; i++) begin
                word_reg[i] <= word_reg[i+1];
            end
            word_reg[NUM_SCHED-1] <= new_word;
        end
    end

endmodule

FILE: rtl/sha1eng_round.sv
// SHA-1 round unit: working variables and one round per step.
module sha1eng_round (
    input  logic                          aclk,
    input  sha1eng_pkg::sha1eng_rnd_ctl_t ctl,
    input  sha1eng_pkg::sha1eng_vars_t    chain_vars,
    input  logic [31:0]                   sched_word,
    output sha1eng_pkg::sha1eng_vars_t    vars
);
    import sha1eng_pkg::*;

    sha1eng_vars_t vars_reg;
    logic [31:0]   f_val;
    logic [31:0]   k_val;
    logic [31:0]   temp;

    always_comb begin
        priority if (ctl.round < ROUND_20) begin
            f_val = (vars_reg.b & vars_reg.c) | (~vars_reg.b & vars_reg.d);
            k_val = K_00_19;
        end else if (ctl.round < ROUND_40) begin
            f_val = vars_reg.b ^ vars_reg.c ^ vars_reg.d;
            k_val = K_20_39;
        end else if (ctl.round < ROUND_60) begin
            f_val = (vars_reg.b & vars_reg.c) | (vars_reg.b & vars_reg.d)
                  | (vars_reg.c & vars_reg.d);
            k_val = K_40_59;
        end else begin
            f_val = vars_reg.b ^ vars_reg.c ^ vars_reg.d;
            k_val = K_60_79;
        end
    end

    assign temp = {vars_reg.a[26:0], vars_reg.a[31:27]} + f_val + vars_reg.e
                + k_val + sched_word;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            vars_reg <= chain_vars;
        end else if (ctl.step) begin
            vars_reg.e <= vars_reg.d;
            vars_reg.d <= vars_reg.c;
            vars_reg.c <= {vars_reg.b[1:0], vars_reg.b[31:2]};
            vars_reg.b <= vars_reg.a;
            vars_reg.a <= temp;
        end
    end

    assign vars = vars_reg;

endmodule

FILE: rtl/sha1_hash_engine.sv
// Top level of the byte-serial SHA-1 hash engine: sequencer, chaining state, output.
//
//  channel | ports                                    | direction | notes
//  --------+------------------------------------------+-----------+-----------------------
//  input   | s_valid s_ready s_data_byte s_has_byte   | in        | up to one byte per transaction
//          | s_last                                   |           | last ends the message
//  result  | m_valid m_ready m_digest_word            | out       | five transactions per
//          | m_word_index m_last_word                 |           | message, word 0 first
//
// Sequence: a byte transaction is taken in idle; the transaction that completes a
//   64-byte block runs the load, 80 rounds through the single round unit and the
//   chaining add. A last transaction adds one padding byte per cycle between
//   compressions (9 to 72 bytes), each block they complete running the same steps,
//   then five digest words at one per cycle while m_ready is high.
// Reset: aresetn (synchronous, active low) restores the initial chaining words
//   and clears length, byte position, sequencer and output valid; no sweep.
// Stalls: s_ready is high only in idle. The digest words leave through an output
//   register, so the engine returns to idle while the final word still waits.
module sha1_hash_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_has_byte,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);
    import sha1eng_pkg::*;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;  // take transactions
    localparam logic [2:0] ST_MARK  = 3'd1;  // push 0x80
    localparam logic [2:0] ST_ZERO  = 3'd2;  // zero fill up to byte 56
    localparam logic [2:0] ST_LEN   = 3'd3;  // eight length bytes, MSB first
    localparam logic [2:0] ST_INIT  = 3'd4;  // load working vars
    localparam logic [2:0] ST_ROUND = 3'd5;  // 80 rounds
    localparam logic [2:0] ST_ADD   = 3'd6;  // fold into chaining words
    localparam logic [2:0] ST_OUT   = 3'd7;  // hand out the digest

    localparam logic [5:0] POS_END = 6'd63;
    localparam logic [5:0] POS_LEN = 6'd55;

    logic [2:0]         state_reg, state_next;
    logic [2:0]         ret_reg, ret_next;
    logic [5:0]         pos_reg, pos_next;
    logic [63:0]        len_reg, len_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [2:0]         idx_reg, idx_next;
    logic [31:0]        chain_reg [NUM_CHAIN];
    logic [31:0]        chain_next [NUM_CHAIN];

    logic               m_valid_reg, m_valid_next;
    logic [31:0]        m_word_reg, m_word_next;
    logic [2:0]         m_idx_reg, m_idx_next;
    logic               m_lastw_reg, m_lastw_next;

    sha1eng_buf_ctl_t   buf_ctl;
    sha1eng_rnd_ctl_t   rnd_ctl;
    sha1eng_vars_t      chain_vars;
    sha1eng_vars_t      vars;
    logic [31:0]        sched_word;
    logic [31:0]        vars_word [NUM_CHAIN];
    logic               in_fire;
    logic               out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign chain_vars = '{a: chain_reg[0], b: chain_reg[1], c: chain_reg[2],
                          d: chain_reg[3], e: chain_reg[4]};
    assign vars_word[0] = vars.a;
    assign vars_word[1] = vars.b;
    assign vars_word[2] = vars.c;
    assign vars_word[3] = vars.d;
    assign vars_word[4] = vars.e;

    sha1eng_msgbuf u_msgbuf (
        .aclk       (aclk),
        .ctl        (buf_ctl),
        .sched_word (sched_word)
    );

    sha1eng_round u_round (
        .aclk       (aclk),
        .ctl        (rnd_ctl),
        .chain_vars (chain_vars),
        .sched_word (sched_word),
        .vars       (vars)
    );

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        round_next   = round_reg;
        idx_next     = idx_reg;
        chain_next   = chain_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_word_next  = m_word_reg;
        m_idx_next   = m_idx_reg;
        m_lastw_next = m_lastw_reg;
        buf_ctl      = '{push: 1'b0, push_byte: 8'h00, step: 1'b0};
        rnd_ctl      = '{load: 1'b0, step: 1'b0, round: round_reg};

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_has_byte) begin
                        buf_ctl.push      = 1'b1;
                        buf_ctl.push_byte = s_data_byte;
                        pos_next          = pos_reg + 6'd1;
                        len_next          = len_reg + 64'd8;
                    end
                    if (s_has_byte && pos_reg == POS_END) begin
                        state_next = ST_INIT;
                        ret_next   = s_last ? ST_MARK : ST_IDLE;
                    end else if (s_last) begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK, ST_ZERO: begin
                buf_ctl.push      = 1'b1;
                buf_ctl.push_byte = (state_reg == ST_MARK) ? PAD_MARK_BYTE : 8'h00;
                pos_next          = pos_reg + 6'd1;
                if (pos_reg == POS_END) begin
                    state_next = ST_INIT;
                    ret_next   = ST_ZERO;
                end else if (pos_reg == POS_LEN) begin
                    state_next = ST_LEN;
                end else begin
                    state_next = ST_ZERO;
                end
            end
            ST_LEN: begin
                // shifting the length out leaves it cleared for the next message
                buf_ctl.push      = 1'b1;
                buf_ctl.push_byte = len_reg[63:56];
                len_next          = {len_reg[55:0], 8'h00};
                pos_next          = pos_reg + 6'd1;
                if (pos_reg == POS_END) begin
                    state_next = ST_INIT;
                    ret_next   = ST_OUT;
                end
            end
            ST_INIT: begin
                rnd_ctl.load = 1'b1;
                round_next   = '0;
                state_next   = ST_ROUND;
            end
            ST_ROUND: begin
                rnd_ctl.step = 1'b1;
                buf_ctl.step = 1'b1;
                round_next   = round_reg + 7'd1;
                if (round_reg == ROUND_LAST) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < NUM_CHAIN; i++) begin
                    chain_next[i] = chain_reg[i] + vars_word[i];
                end
                state_next = ret_reg;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_word_next  = chain_reg[idx_reg];
                    m_idx_next   = idx_reg;
                    m_lastw_next = (idx_reg == LAST_WORD_IDX);
                    idx_next     = idx_reg + 3'd1;
                    if (idx_reg == LAST_WORD_IDX) begin
                        idx_next   = '0;
                        chain_next = INIT_H;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            pos_reg     <= '0;
            len_reg     <= '0;
            round_reg   <= '0;
            idx_reg     <= '0;
            chain_reg   <= INIT_H;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            round_reg   <= round_next;
            idx_reg     <= idx_next;
            chain_reg   <= chain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        m_word_reg  <= m_word_next;
        m_idx_reg   <= m_idx_next;
        m_lastw_reg <= m_lastw_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_digest_word = m_word_reg;
    assign m_word_index  = m_idx_reg;
    assign m_last_word   = m_lastw_reg;

endmodule

FILE: test/tb_sha1_hash_engine.sv
// Self-checking testbench for sha1_hash_engine: byte stream in, digest words out.
module tb_sha1_hash_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1eng_pkg::*;

    // Watchdog: longest quiet spell is the one output hold-off plus a
    // worst-case padding pass (two compressions), taken several times over.
    localparam int IDLE_LIMIT     = 4000;
    localparam int TAIL_CYCLES    = 200;
    localparam int STIM_TARGET    = 420;   // counted ones; empty noise brings it near 470
    localparam int MAX_GAP        = 12;
    localparam int HOLD_AT_WORD   = 12;    // digest word that starts the hold-off
    localparam int HOLD_CYCLES    = 400;

    // One input transaction plus the sender's pacing for it.
    typedef struct {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
        int         gap;
        bit         drain_first;  // hold it back until all digests are out
    } stim_item_t;

    // One digest word as the result channel should carry it.
    typedef struct {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_has_byte = 1'b0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    stim_item_t  pending_q [$];
    digest_res_t expected_digest_q [$];

    // Shadow copy of the hash state.
    logic [31:0] chain_h [5];
    logic [31:0] blk_w [16];
    logic [63:0] msg_bits;
    logic [5:0]  blk_pos;

    int err_count   = 0;
    int stim_items  = 0;
    int msg_queued  = 0;
    int bytes_sent  = 0;
    int msgs_done   = 0;
    int words_seen  = 0;

    sha1_hash_engine i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_has_byte    (s_has_byte),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Digest predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void sha1_restart();
        chain_h[0] = 32'h67452301;
        chain_h[1] = 32'hEFCDAB89;
        chain_h[2] = 32'h98BADCFE;
        chain_h[3] = 32'h10325476;
        chain_h[4] = 32'hC3D2E1F0;
        msg_bits   = '0;
        blk_pos    = '0;
    endfunction

    // 80 rounds over the buffered block, schedule kept in a 16-word ring.
    function automatic void sha1_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        w = blk_w;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++) begin
            if (r >= 16)
                w[r % 16] = rol32(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^
                                  w[(r + 2) % 16] ^ w[r % 16], 1);
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K_00_19;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_20_39;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_40_59;
            end else begin
                f = b ^ c ^ d;
                k = K_60_79;
            end
            t = rol32(a, 5) + f + e + k + w[r % 16];
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    // Big-endian byte packing; a full block triggers compression.
    function automatic void sha1_put_byte(input logic [7:0] bval);
        int sh;
        sh = 8 * (3 - int'(blk_pos[1:0]));
        if (blk_pos[1:0] == 2'd0)
            blk_w[blk_pos[5:2]] = '0;
        blk_w[blk_pos[5:2]][sh +: 8] = bval;
        blk_pos = blk_pos + 6'd1;
        if (blk_pos == 6'd0)
            sha1_compress();
    endfunction

    // Absorb one accepted transaction; on last, pad and queue five words.
    function automatic void sha1_predict(input stim_item_t it);
        logic [63:0] len;
        digest_res_t res;
        if (it.has_byte) begin
            sha1_put_byte(it.data_byte);
            msg_bits += 64'd8;
            bytes_sent++;
        end
        if (it.last) begin
            len = msg_bits;
            sha1_put_byte(PAD_MARK_BYTE);
            while (blk_pos != 6'd56)
                sha1_put_byte(8'h00);
            for (int i = 0; i < 8; i++)
                sha1_put_byte(len[8 * (7 - i) +: 8]);
            for (int i = 0; i < 5; i++) begin
                res.digest_word = chain_h[i];
                res.word_index  = 3'(i);
                res.last_word   = (3'(i) == LAST_WORD_IDX);
                expected_digest_q.insert(expected_digest_q.size(), res);
            end
            sha1_restart();
            msgs_done++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic add_item(input logic [7:0] dbyte, input logic hb, input logic lst,
                            input int gap, input bit drain);
        stim_item_t it;
        it.data_byte   = dbyte;
        it.has_byte    = hb;
        it.last        = lst;
        it.gap         = gap;
        it.drain_first = drain;
        pending_q.insert(pending_q.size(), it);
        if (hb || lst)
            stim_items++;
    endtask

    // Random-content message. last rides on the final byte or on its own
    // byteless transaction; empty transactions are sprinkled in as noise.
    task automatic queue_message(input int nbytes, input bit last_on_byte,
                                 input bit burst, input bit drain);
        int  gap;
        bit  is_end;
        for (int i = 0; i < nbytes; i++) begin
            gap = burst ? 0 : $urandom_range(0, MAX_GAP);
            if (!burst && $urandom_range(0, 9) == 0)
                add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, gap, 1'b0);
            is_end = last_on_byte && (i == nbytes - 1);
            add_item(8'($urandom_range(0, 255)), 1'b1, is_end, gap, drain && i == 0);
        end
        if (!last_on_byte || nbytes == 0)
            add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1,
                     burst ? 0 : $urandom_range(0, MAX_GAP), drain && nbytes == 0);
        msg_queued++;
    endtask

    // ------------------------------------------------------------------
    // Driver: pops pending transactions, waits out their gap, presents them
    // ------------------------------------------------------------------
    stim_item_t staged_item;
    bit         have_staged = 1'b0;
    int         send_gap = 0;
    logic       drv_valid_next;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // Predict on acceptance, before anything new is staged.
            if (s_valid && s_ready)
                sha1_predict('{s_data_byte, s_has_byte, s_last, 0, 1'b0});
            drv_valid_next = s_valid && !s_ready;
            if (!drv_valid_next) begin
                // A drain-first transaction waits for every digest word.
                if (!have_staged && pending_q.size() != 0 &&
                    !(pending_q[0].drain_first && expected_digest_q.size() != 0)) begin
                    staged_item = pending_q.pop_front();
                    send_gap    = staged_item.gap;
                    have_staged = 1'b1;
                end
                if (have_staged && send_gap == 0) begin
                    s_data_byte    <= staged_item.data_byte;
                    s_has_byte     <= staged_item.has_byte;
                    s_last         <= staged_item.last;
                    drv_valid_next = 1'b1;
                    have_staged    = 1'b0;
                end else if (have_staged) begin
                    send_gap--;
                end
            end
            s_valid <= drv_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each digest transaction and paces m_ready
    // ------------------------------------------------------------------
    digest_res_t head_res;
    int          recv_wait = 0;
    int          hold_left = 0;
    bit          recv_burst = 1'b0;
    logic        rdy_next;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                words_seen++;
                if (expected_digest_q.size() == 0) begin
                    $error("unexpected digest transaction: word %08h index %0d",
                           m_digest_word, m_word_index);
                    err_count++;
                end else begin
                    head_res = expected_digest_q.pop_front();
                    if (m_digest_word !== head_res.digest_word) begin
                        $error("digest_word: expected %08h, actual %08h",
                               head_res.digest_word, m_digest_word);
                        err_count++;
                    end
                    if (m_word_index !== head_res.word_index) begin
                        $error("word_index: expected %0d, actual %0d",
                               head_res.word_index, m_word_index);
                        err_count++;
                    end
                    if (m_last_word !== head_res.last_word) begin
                        $error("last_word: expected %0b, actual %0b",
                               head_res.last_word, m_last_word);
                        err_count++;
                    end
                end
                // Flip between stall-free stretches and random stalls.
                if ($urandom_range(0, 5) == 0)
                    recv_burst = !recv_burst;
                recv_wait = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
                // One long hold-off so the engine backs up into s_ready.
                if (words_seen == HOLD_AT_WORD)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy_next = 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                rdy_next = 1'b0;
            end else begin
                rdy_next = 1'b1;
            end
            m_ready <= rdy_next;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too many cycles with no transaction on either channel
    // ------------------------------------------------------------------
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no transaction for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: build stimulus, reset, wait for drain, report
    // ------------------------------------------------------------------
    initial begin : main_seq
        int len;
        sha1_restart();
        for (int i = 0; i < 16; i++)
            blk_w[i] = '0;

        // Directed: empty transaction, empty message, "abc" with last on the
        // final byte, "abc" with a separate last, byte extremes, noise mid-message.
        add_item(8'hFF, 1'b0, 1'b0, 0, 1'b0);
        add_item(8'hA5, 1'b0, 1'b1, 0, 1'b0);
        add_item(8'h61, 1'b1, 1'b0, 0, 1'b0);
        add_item(8'h62, 1'b1, 1'b0, 3, 1'b0);
        add_item(8'h63, 1'b1, 1'b1, 0, 1'b0);
        add_item(8'h61, 1'b1, 1'b0, 0, 1'b1);
        add_item(8'h62, 1'b1, 1'b0, 0, 1'b0);
        add_item(8'h63, 1'b1, 1'b0, 0, 1'b0);
        add_item(8'h00, 1'b0, 1'b1, 5, 1'b0);
        add_item(8'h00, 1'b1, 1'b0, 0, 1'b0);
        add_item(8'h5A, 1'b0, 1'b0, 2, 1'b0);
        add_item(8'hFF, 1'b1, 1'b0, 0, 1'b0);
        add_item(8'h80, 1'b1, 1'b1, 12, 1'b0);
        msg_queued = 4;

        // Random messages; lengths lean toward the padding boundaries so the
        // one- and two-block padding paths both get plenty of traffic.
        while (stim_items < STIM_TARGET) begin
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0: len = 0;
                    1: len = 55;
                    2: len = 56;
                    3: len = 57;
                    4: len = 63;
                    5: len = 64;
                    6: len = 65;
                    7: len = 119;
                    8: len = 120;
                    default: len = 128;
                endcase
            end else begin
                len = $urandom_range(0, 40);
            end
            queue_message(len, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                          msg_queued % 9 == 5);
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() != 0 || have_staged || s_valid)
            @(posedge aclk);
        while (expected_digest_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d input transactions (%0d bytes) in %0d messages,",
                 stim_items, bytes_sent, msgs_done);
        $display("  %0d digest words checked, with back-pressure and a drained pause.",
                 words_seen);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/sha1eng_pkg.sv
rtl/sha1eng_msgbuf.sv
rtl/sha1eng_round.sv
rtl/sha1_hash_engine.sv
test/tb_sha1_hash_engine.sv
